>>> rtl/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// LZW encoder package
// Shared constants and types for the fixed-width LZW byte encoder.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int LZWE_CODE_BITS  = 12;
    localparam int LZWE_TABLE_SIZE = 5003;
    localparam int LZWE_END_CODE   = 256;
    localparam int LZWE_FIRST_FREE = 257;

    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // One input beat as held in the input queue.
    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
    } t_item;

    // Command from the dictionary engine to the bit packer.
    typedef struct packed {
        logic valid;
        logic flush;
    } t_pack_ctl;

endpackage

>>> rtl/lzw_byte_encoder.sv
// ----------------------------------------------------------------------------
// LZW byte encoder
// Fixed-width LZW compressor emitting codes packed LSB first as bytes.
// ----------------------------------------------------------------------------
// Usage: each input beat is either a data byte (i_req_type low) or an end of
// stream marker (i_req_type high). Output beats carry packed code bytes, and
// o_last_byte marks the final, possibly all-zero, byte of a stream.
// Input beats enter a two-entry queue, so the port keeps taking beats while
// the dictionary engine searches. A data byte that follows a held prefix
// passes ST_MOD, which subtracts TABLE_SIZE from the hash until it lies
// inside the table, then ST_READ and ST_CHECK; each further probe of the
// single-port dictionary memory repeats ST_READ and ST_CHECK. A miss then
// waits in ST_SEND to hand the prefix code to the bit packer.
// After reset and after each end of stream the engine sweeps all TABLE_SIZE
// dictionary slots (5003 at the defaults) to mark every slot empty; the
// queue still accepts up to two beats meanwhile.
// Results leave through an output register. When the receiver stalls, the
// packer and then the engine hold, and the input queue fills and drops
// o_ready. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module lzw_byte_encoder #(
    parameter int CODE_BITS  = lzwe_pkg::LZWE_CODE_BITS,
    parameter int TABLE_SIZE = lzwe_pkg::LZWE_TABLE_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_req_type,
    input  logic [7:0] i_byte_value,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_byte
);
    import lzwe_pkg::*;

    t_item                q_item_in;
    t_item                q_item;
    logic                 q_valid;
    logic                 q_pop;
    t_pack_ctl            cmd;
    logic [CODE_BITS-1:0] cmd_code;
    logic                 cmd_ready;
    logic                 clearing;

    assign q_item_in.req_type   = i_req_type;
    assign q_item_in.byte_value = i_byte_value;

    // Front: buffers accepted beats for the engine.
    lzwe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (q_item_in),
        .o_item_valid (q_valid),
        .o_item       (q_item),
        .i_pop        (q_pop)
    );

    // Back: dictionary search and stream sequencing.
    lzwe_core #(
        .CODE_BITS  (CODE_BITS),
        .TABLE_SIZE (TABLE_SIZE)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_cmd        (cmd),
        .o_code       (cmd_code),
        .i_cmd_ready  (cmd_ready),
        .o_clearing   (clearing)
    );

    // Bit packer with the output register.
    lzwe_pack #(
        .CODE_BITS (CODE_BITS)
    ) u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_code      (cmd_code),
        .o_cmd_ready (cmd_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    // The engine never issues codes while it sweeps the dictionary.
    a_no_cmd_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !cmd.valid)
        else $error("code issued during dictionary sweep");

    // A flush taken by the packer starts the dictionary sweep.
    a_flush_starts_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.valid && cmd.flush && cmd_ready) |=> clearing)
        else $error("flush did not start dictionary sweep");

    // The engine never pops the queue while sweeping.
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !q_pop)
        else $error("queue popped during dictionary sweep");

endmodule

>>> rtl/lzwe_queue.sv
// ----------------------------------------------------------------------------
// LZW input queue
// Two-entry queue between the input port and the dictionary engine.
// ----------------------------------------------------------------------------
module lzwe_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lzwe_pkg::t_item i_item,
    output logic            o_item_valid,
    output lzwe_pkg::t_item o_item,
    input  logic            i_pop
);
    import lzwe_pkg::*;

    t_item       r_ent [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign o_ready      = (r_cnt != 2'd2);
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_ent[r_rp];
    assign push         = i_valid && o_ready;
    assign pop          = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> rtl/lzwe_core.sv
// ----------------------------------------------------------------------------
// LZW dictionary engine
// Hash probe search, insertion and end-of-stream sequencing over the
// dictionary memory, issuing codes and flushes to the bit packer.
// ----------------------------------------------------------------------------
module lzwe_core #(
    parameter int CODE_BITS  = lzwe_pkg::LZWE_CODE_BITS,
    parameter int TABLE_SIZE = lzwe_pkg::LZWE_TABLE_SIZE
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  lzwe_pkg::t_item       i_item,
    output logic                  o_pop,
    output lzwe_pkg::t_pack_ctl   o_cmd,
    output logic [CODE_BITS-1:0]  o_code,
    input  logic                  i_cmd_ready,
    output logic                  o_clearing
);
    import lzwe_pkg::*;

    localparam int AW = $clog2(TABLE_SIZE);
    localparam int PW = (CODE_BITS > AW) ? CODE_BITS : AW;
    localparam int TW = $clog2(TABLE_SIZE);
    localparam int EW = 1 + CODE_BITS + 8 + CODE_BITS;
    // Entry layout: {valid, prefix, byte, code}
    localparam int E_CODE_LO = 0;
    localparam int E_BYTE_LO = CODE_BITS;
    localparam int E_PRE_LO  = CODE_BITS + 8;
    localparam int E_VALID   = EW - 1;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_MOD      = 4'd2;
    localparam logic [3:0] ST_READ     = 4'd3;
    localparam logic [3:0] ST_CHECK    = 4'd4;
    localparam logic [3:0] ST_SEND     = 4'd5;
    localparam logic [3:0] ST_END_PRE  = 4'd6;
    localparam logic [3:0] ST_END_CODE = 4'd7;
    localparam logic [3:0] ST_FLUSH    = 4'd8;

    logic [EW-1:0]        r_mem [TABLE_SIZE];
    logic [EW-1:0]        r_rd;

    logic [3:0]           r_state,  n_state;
    logic [PW-1:0]        r_probe,  n_probe;
    logic [TW-1:0]        r_tries,  n_tries;
    logic [AW-1:0]        r_clr,    n_clr;
    logic [CODE_BITS-1:0] r_prefix, n_prefix;
    logic                 r_have,   n_have;
    logic [CODE_BITS:0]   r_next,   n_next;
    logic [7:0]           r_byte,   n_byte;

    logic                 mem_we;
    logic [AW-1:0]        wa;
    logic [EW-1:0]        wd;
    logic [8:0]           step;
    logic                 e_valid;
    logic [CODE_BITS-1:0] e_prefix;
    logic [7:0]           e_byte;
    logic [CODE_BITS-1:0] e_code;

    assign step     = {1'b1, r_byte};
    assign e_valid  = r_rd[E_VALID];
    assign e_prefix = r_rd[E_PRE_LO +: CODE_BITS];
    assign e_byte   = r_rd[E_BYTE_LO +: 8];
    assign e_code   = r_rd[E_CODE_LO +: CODE_BITS];
    assign o_clearing = (r_state == ST_CLEAR);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wa] <= wd;
        end
        if (r_state == ST_READ) begin
            r_rd <= r_mem[r_probe[AW-1:0]];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_probe  = r_probe;
        n_tries  = r_tries;
        n_clr    = r_clr;
        n_prefix = r_prefix;
        n_have   = r_have;
        n_next   = r_next;
        n_byte   = r_byte;
        mem_we   = 1'b0;
        wa       = r_probe[AW-1:0];
        wd       = '0;
        o_pop    = 1'b0;
        o_cmd    = '0;
        o_code   = r_prefix;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                wa     = r_clr;
                if (r_clr == AW'(TABLE_SIZE - 1)) begin
                    n_clr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    if (i_item.req_type == REQ_END) begin
                        n_state = r_have ? ST_END_PRE : ST_END_CODE;
                    end else if (!r_have) begin
                        n_prefix = CODE_BITS'(i_item.byte_value);
                        n_have   = 1'b1;
                    end else begin
                        n_byte  = i_item.byte_value;
                        n_probe = PW'({i_item.byte_value, 1'b0}) ^ PW'(r_prefix);
                        n_tries = '0;
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (r_probe >= PW'(TABLE_SIZE)) begin
                    n_probe = r_probe - PW'(TABLE_SIZE);
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (!e_valid) begin
                    if (!r_next[CODE_BITS]) begin
                        mem_we = 1'b1;
                        wd     = {1'b1, r_prefix, r_byte, r_next[CODE_BITS-1:0]};
                        n_next = r_next + 1'b1;
                    end
                    n_state = ST_SEND;
                end else if (e_prefix == r_prefix && e_byte == r_byte) begin
                    n_prefix = e_code;
                    n_state  = ST_IDLE;
                end else if (r_tries == TW'(TABLE_SIZE - 1)) begin
                    n_state = ST_SEND;
                end else begin
                    n_tries = r_tries + 1'b1;
                    if (r_probe >= PW'(step)) begin
                        n_probe = r_probe - PW'(step);
                    end else begin
                        n_probe = r_probe + PW'(TABLE_SIZE) - PW'(step);
                    end
                    n_state = ST_READ;
                end
            end
            ST_SEND: begin
                o_cmd.valid = 1'b1;
                if (i_cmd_ready) begin
                    n_prefix = CODE_BITS'(r_byte);
                    n_state  = ST_IDLE;
                end
            end
            ST_END_PRE: begin
                o_cmd.valid = 1'b1;
                if (i_cmd_ready) begin
                    n_state = ST_END_CODE;
                end
            end
            ST_END_CODE: begin
                o_cmd.valid = 1'b1;
                o_code      = CODE_BITS'(LZWE_END_CODE);
                if (i_cmd_ready) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                o_cmd.valid = 1'b1;
                o_cmd.flush = 1'b1;
                if (i_cmd_ready) begin
                    n_have   = 1'b0;
                    n_prefix = '0;
                    n_next   = (CODE_BITS + 1)'(LZWE_FIRST_FREE);
                    n_state  = ST_CLEAR;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
        r_tries <= n_tries;
        r_byte  <= n_byte;
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_prefix <= '0;
            r_have   <= 1'b0;
            r_next   <= (CODE_BITS + 1)'(LZWE_FIRST_FREE);
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_prefix <= n_prefix;
            r_have   <= n_have;
            r_next   <= n_next;
        end
    end

endmodule

>>> rtl/lzwe_pack.sv
// ----------------------------------------------------------------------------
// LZW bit packer
// Packs codes least significant bit first into bytes behind an output register.
// ----------------------------------------------------------------------------
module lzwe_pack #(
    parameter int CODE_BITS = lzwe_pkg::LZWE_CODE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lzwe_pkg::t_pack_ctl  i_cmd,
    input  logic [CODE_BITS-1:0] i_code,
    output logic                 o_cmd_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last_byte
);
    import lzwe_pkg::*;

    localparam int BW = CODE_BITS + 7;
    localparam int CW = $clog2(BW + 1);

    logic [BW-1:0] r_buf;
    logic [CW-1:0] r_cnt;
    logic          r_ov;
    logic [7:0]    r_ob;
    logic          r_ol;
    logic          slot_free;
    logic          have_byte;

    assign slot_free   = !r_ov || i_ready;
    assign have_byte   = (r_cnt >= CW'(8));
    assign o_cmd_ready = !have_byte && (!i_cmd.flush || slot_free);
    assign o_valid     = r_ov;
    assign o_out_byte  = r_ob;
    assign o_last_byte = r_ol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
            r_ob  <= '0;
            r_ol  <= 1'b0;
        end else if (have_byte && slot_free) begin
            r_ov  <= 1'b1;
            r_ob  <= r_buf[7:0];
            r_ol  <= 1'b0;
            r_buf <= r_buf >> 8;
            r_cnt <= r_cnt - CW'(8);
        end else if (i_cmd.valid && o_cmd_ready && i_cmd.flush) begin
            r_ov  <= 1'b1;
            r_ob  <= r_buf[7:0];
            r_ol  <= 1'b1;
            r_buf <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.valid && o_cmd_ready) begin
                r_buf <= r_buf | (BW'(i_code) << r_cnt);
                r_cnt <= r_cnt + CW'(CODE_BITS);
            end
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

endmodule

>>> dv/lzw_byte_encoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW byte encoder testbench
// Streams of data bytes and end markers are driven through the valid/ready
// input port. A behavioral dictionary model predicts every packed output
// byte, and a monitor checks each output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_test;

    import lzwe_pkg::*;

    localparam int TSIZE = LZWE_TABLE_SIZE;
    localparam int CBITS = LZWE_CODE_BITS;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_req_type = REQ_DATA;
    logic [7:0] i_byte_value = 8'd0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_last_byte;

    lzw_byte_encoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_byte_value(i_byte_value),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_byte(o_out_byte), .o_last_byte(o_last_byte)
    );

    always #1 i_clk = ~i_clk;

    // Dictionary model state.
    bit        dict_used [TSIZE];
    bit [11:0] dict_prefix [TSIZE];
    bit [7:0]  dict_byte [TSIZE];
    bit [11:0] dict_code [TSIZE];
    int        next_code;
    bit [11:0] cur_prefix;
    bit        prefix_held;
    bit [7:0]  pack_acc;
    int        pack_free;

    // Expected output bytes, each packed as {last, byte}.
    bit [8:0]  expected_bytes [$];
    t_item     pending_items [$];

    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  streams_done = 0;
    bit  no_idle = 1'b0;
    bit  long_hold = 1'b0;
    bit  send_pause = 1'b0;

    task automatic clear_dict();
        for (int i = 0; i < TSIZE; i++) dict_used[i] = 1'b0;
        next_code = LZWE_FIRST_FREE;
        cur_prefix = '0;
        prefix_held = 1'b0;
        pack_acc = '0;
        pack_free = 8;
    endtask

    // Appends a code LSB first, pushing each completed byte.
    task automatic pack_code(input bit [11:0] code);
        int k;
        int n;
        bit [11:0] c;
        k = CBITS;
        c = code;
        while (k > 0) begin
            n = (pack_free < k) ? pack_free : k;
            pack_acc = pack_acc | 8'((c & ((12'd1 << n) - 12'd1)) << (8 - pack_free));
            c = c >> n;
            pack_free -= n;
            k -= n;
            if (pack_free == 0) begin
                expected_bytes.push_back({1'b0, pack_acc});
                pack_acc = '0;
                pack_free = 8;
            end
        end
    endtask

    // Computes the output bytes that one input beat causes.
    task automatic compress_beat(input t_item it);
        int probe;
        int step;
        int tries;
        bit hit;
        bit empty;
        if (it.req_type == REQ_END) begin
            if (prefix_held) pack_code(cur_prefix);
            pack_code(12'(LZWE_END_CODE));
            expected_bytes.push_back({1'b1, pack_acc});
            clear_dict();
            return;
        end
        if (!prefix_held) begin
            cur_prefix = 12'(it.byte_value);
            prefix_held = 1'b1;
            return;
        end
        probe = ((int'(it.byte_value) << 1) ^ int'(cur_prefix)) % TSIZE;
        step = int'(it.byte_value) | 256;
        tries = 0;
        hit = 1'b0;
        empty = 1'b0;
        while (tries < TSIZE) begin
            if (!dict_used[probe]) begin
                empty = 1'b1;
                break;
            end
            if (dict_prefix[probe] == cur_prefix && dict_byte[probe] == it.byte_value) begin
                hit = 1'b1;
                break;
            end
            probe = (probe >= step) ? probe - step : probe + TSIZE - step;
            tries++;
        end
        if (hit) begin
            cur_prefix = dict_code[probe];
        end else begin
            pack_code(cur_prefix);
            if (empty && next_code < (1 << CBITS)) begin
                dict_used[probe] = 1'b1;
                dict_prefix[probe] = cur_prefix;
                dict_byte[probe] = it.byte_value;
                dict_code[probe] = 12'(next_code);
                next_code++;
            end
            cur_prefix = 12'(it.byte_value);
        end
    endtask

    function automatic t_item data_beat(input bit [7:0] b);
        t_item it;
        it.req_type = REQ_DATA;
        it.byte_value = b;
        return it;
    endfunction

    function automatic t_item end_beat();
        t_item it;
        it.req_type = REQ_END;
        it.byte_value = 8'($urandom);
        return it;
    endfunction

    // The acceptance of an input beat, seen at the rising edge.
    logic took_q = 1'b0;
    always @(posedge i_clk) begin
        took_q <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready) begin
            compress_beat('{req_type: i_req_type, byte_value: i_byte_value});
            beats_in++;
            if (i_req_type == REQ_END) streams_done++;
        end
    end

    // Driver: presents the head of the pending queue, holding it until the
    // beat is taken. Idle bursts are inserted only between beats.
    int send_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || took_q) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0 && !send_pause) begin
                    i_req_type <= pending_items[0].req_type;
                    i_byte_value <= pending_items[0].byte_value;
                    pending_items.pop_front();
                    i_valid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 11);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness: random stall bursts, plus one long hold-off.
    int recv_gap = 0;
    int hold_count = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (long_hold) begin
            i_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else if (no_idle) begin
            i_ready <= 1'b1;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 11);
        end
    end

    // Monitor: every output beat is compared with the oldest prediction.
    always @(posedge i_clk) begin
        bit [8:0] exp_b;
        if (i_rst_n && o_valid && i_ready) begin
            beats_out++;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected output beat, actual byte %h last %b",
                         $time, o_out_byte, o_last_byte);
                errors++;
            end else begin
                exp_b = expected_bytes.pop_front();
                if (o_out_byte !== exp_b[7:0]) begin
                    $display("%0t: out_byte mismatch, expected %h actual %h",
                             $time, exp_b[7:0], o_out_byte);
                    errors++;
                end
                if (o_last_byte !== exp_b[8]) begin
                    $display("%0t: last_byte mismatch, expected %b actual %b",
                             $time, exp_b[8], o_last_byte);
                    errors++;
                end
            end
        end
    end

    // Fills a stream with random content: repetitive text from a small
    // alphabet so the dictionary gets long chains of hits, or full-range
    // noise bytes.
    task automatic add_stream(input int len, input bit narrow);
        for (int i = 0; i < len; i++) begin
            if (narrow) pending_items.push_back(data_beat(8'($urandom_range(97, 100))));
            else pending_items.push_back(data_beat(8'($urandom)));
        end
        pending_items.push_back(end_beat());
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || i_valid || expected_bytes.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        clear_dict();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: an empty stream, a one-byte stream, the byte extremes,
        // and repeated bytes that hit the dictionary.
        pending_items.push_back(end_beat());
        pending_items.push_back(data_beat(8'h00));
        pending_items.push_back(end_beat());
        pending_items.push_back(data_beat(8'hFF));
        pending_items.push_back(data_beat(8'h00));
        pending_items.push_back(data_beat(8'hFF));
        pending_items.push_back(data_beat(8'hFF));
        pending_items.push_back(end_beat());
        for (int i = 0; i < 10; i++) pending_items.push_back(data_beat(8'h41));
        pending_items.push_back(data_beat(8'hAA));
        pending_items.push_back(data_beat(8'h55));
        pending_items.push_back(end_beat());
        wait_drained();

        // The sender pauses once all expected output has drained.
        send_pause = 1'b1;
        repeat (20) @(posedge i_clk);
        send_pause = 1'b0;

        // The receiver holds off for a long stretch while beats keep coming.
        add_stream(40, 1'b0);
        long_hold = 1'b1;
        while (hold_count < 400) @(posedge i_clk);
        long_hold = 1'b0;
        wait_drained();

        // Random streams, mostly short, one long enough to build deep chains.
        add_stream(150, 1'b1);
        for (int s = 0; s < 14; s++)
            add_stream($urandom_range(0, 20), $urandom_range(0, 1));
        wait_drained();

        // Final part with no idling on either side.
        no_idle = 1'b1;
        for (int s = 0; s < 4; s++) add_stream($urandom_range(5, 25), $urandom_range(0, 1));
        wait_drained();
        repeat (6000) @(posedge i_clk);

        $display("Covered %0d input beats in %0d streams, %0d output bytes checked.",
                 beats_in, streams_done, beats_out);
        if (errors == 0 && expected_bytes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> lzw_byte_encoder.f
rtl/lzwe_pkg.sv
rtl/lzwe_queue.sv
rtl/lzwe_core.sv
rtl/lzwe_pack.sv
rtl/lzw_byte_encoder.sv
dv/lzw_byte_encoder_test.sv
